>>> rtl/ecrb_pkg.sv
package ecrb_pkg;

    // Element IDs, with their vint marker kept.
    localparam logic [31:0] CLUSTER_ID   = 32'h1F43_B675;
    localparam logic [31:0] TIMECODE_ID  = 32'h0000_00E7;
    // Size code written ahead of a rewritten timecode: eight data bytes.
    localparam logic [7:0]  TC_SIZE_CODE = 8'h88;

    // Entries in the queue between the parser and the emitter.
    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_NOT_CLUSTER = 3'd1,
        ST_OVERRUN     = 3'd2,
        ST_NO_TIMECODE = 3'd3,
        ST_BAD_VINT    = 3'd4,
        ST_TOO_LONG    = 3'd5
    } status_t;

    // Parser phases, one-hot.
    typedef enum logic [7:0] {
        PH_CL_ID   = 8'b0000_0001,
        PH_CL_SIZE = 8'b0000_0010,
        PH_CH_ID   = 8'b0000_0100,
        PH_CH_SIZE = 8'b0000_1000,
        PH_CH_DATA = 8'b0001_0000,
        PH_TC_SIZE = 8'b0010_0000,
        PH_TC_DATA = 8'b0100_0000,
        PH_TAIL    = 8'b1000_0000
    } phase_t;

    // One command from the parser: either one output byte or a timecode to rebase.
    typedef struct packed {
        logic        is_tc;
        logic [7:0]  data;
        logic        valid;
        status_t     status;
        logic        cend;
        logic [63:0] tc;
    } cmd_t;

    // Length of a vint from its first byte; 9 for a zero byte.
    function automatic logic [3:0] vint_len(input logic [7:0] b);
        logic [3:0] n;
        casez (b)
            8'b1???_????: n = 4'd1;
            8'b01??_????: n = 4'd2;
            8'b001?_????: n = 4'd3;
            8'b0001_????: n = 4'd4;
            8'b0000_1???: n = 4'd5;
            8'b0000_01??: n = 4'd6;
            8'b0000_001?: n = 4'd7;
            8'b0000_0001: n = 4'd8;
            default:      n = 4'd9;
        endcase
        return n;
    endfunction

endpackage

>>> rtl/ecrb_front.sv
module ecrb_front
    import ecrb_pkg::*;
#(
    parameter int unsigned LENGTH_BITS = 24
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       s_tuser,
    input  logic       q_full,
    output logic       push,
    output cmd_t       push_cmd
);

    phase_t                 phase_reg, phase_next;
    logic [63:0]            accum_reg, accum_next;
    logic [3:0]             fbl_reg, fbl_next;
    logic [3:0]             vlen_reg, vlen_next;
    logic [LENGTH_BITS-1:0] cbl_reg, cbl_next;
    logic [LENGTH_BITS-1:0] child_reg, child_next;
    logic                   err_reg, err_next;

    logic                   accept;
    phase_t                 ph;
    logic [63:0]            acc;
    logic [3:0]             fbl;
    logic                   errl;
    logic [3:0]             n;
    logic                   first;
    logic [63:0]            take_acc;
    logic [3:0]             take_fbl;
    logic [3:0]             take_len;
    logic                   done;
    logic [5:0]             dbits;
    logic [63:0]            dmask;
    logic [63:0]            dval;
    logic                   size_bad;
    logic [LENGTH_BITS-1:0] size_val;
    logic [LENGTH_BITS-1:0] n_ext;
    logic [LENGTH_BITS-1:0] cbl_dec;
    logic [LENGTH_BITS-1:0] child_dec;
    status_t                err;
    logic                   put_byte;
    logic                   put_tc;
    logic [63:0]            tc_val;
    logic                   close;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && !q_full;

    // Start of a cluster resynchronizes the parser.
    assign ph   = s_tuser ? PH_CL_ID : phase_reg;
    assign acc  = s_tuser ? 64'd0 : accum_reg;
    assign fbl  = s_tuser ? 4'd0 : fbl_reg;
    assign errl = s_tuser ? 1'b0 : err_reg;

    // Vint byte gathering.
    assign n        = vint_len(s_tdata);
    assign first    = (fbl == 4'd0);
    assign take_acc = first ? {56'd0, s_tdata} : {acc[55:0], s_tdata};
    assign take_fbl = first ? (n - 4'd1) : (fbl - 4'd1);
    assign take_len = first ? n : vlen_reg;
    assign done     = (take_fbl == 4'd0);

    // Size vint decode: the marker sits at bit 7*length.
    assign dbits    = 6'(take_len) * 6'd7;
    assign dmask    = (64'd1 << dbits) - 64'd1;
    assign dval     = take_acc & dmask;
    assign size_bad = (dval == dmask) || ((dval >> LENGTH_BITS) != 64'd0);
    assign size_val = dval[LENGTH_BITS-1:0];

    assign n_ext     = LENGTH_BITS'(n);
    assign cbl_dec   = cbl_reg - LENGTH_BITS'(1);
    assign child_dec = child_reg - LENGTH_BITS'(1);

    // Per-byte parse step.
    always_comb begin
        phase_next = phase_reg;
        accum_next = accum_reg;
        fbl_next   = fbl_reg;
        vlen_next  = vlen_reg;
        cbl_next   = cbl_reg;
        child_next = child_reg;
        err_next   = err_reg;
        err        = ST_OK;
        put_byte   = 1'b0;
        put_tc     = 1'b0;
        tc_val     = 64'd0;
        close      = 1'b0;
        if (accept && !errl) begin
            phase_next = ph;
            accum_next = acc;
            fbl_next   = fbl;
            err_next   = 1'b0;
            unique case (ph)
                PH_CL_ID: begin
                    if (first && n > 4'd4) begin
                        err = ST_BAD_VINT;
                    end else begin
                        put_byte   = 1'b1;
                        accum_next = take_acc;
                        fbl_next   = take_fbl;
                        vlen_next  = take_len;
                        if (done) begin
                            if (take_acc[31:0] != CLUSTER_ID) begin
                                err = ST_NOT_CLUSTER;
                            end else begin
                                phase_next = PH_CL_SIZE;
                            end
                        end
                    end
                end
                PH_CL_SIZE: begin
                    if (first && n > 4'd8) begin
                        err = ST_BAD_VINT;
                    end else begin
                        put_byte   = 1'b1;
                        accum_next = take_acc;
                        fbl_next   = take_fbl;
                        vlen_next  = take_len;
                        if (done) begin
                            if (size_bad) begin
                                err = ST_TOO_LONG;
                            end else if (size_val == '0) begin
                                err = ST_NO_TIMECODE;
                            end else begin
                                cbl_next   = size_val;
                                phase_next = PH_CH_ID;
                            end
                        end
                    end
                end
                PH_CH_ID: begin
                    if (first && n > 4'd4) begin
                        err = ST_BAD_VINT;
                    end else if (first && n_ext > cbl_reg) begin
                        err = ST_OVERRUN;
                    end else begin
                        put_byte   = 1'b1;
                        accum_next = take_acc;
                        fbl_next   = take_fbl;
                        vlen_next  = take_len;
                        cbl_next   = cbl_dec;
                        if (done) begin
                            phase_next = (take_acc[31:0] == TIMECODE_ID) ? PH_TC_SIZE
                                                                         : PH_CH_SIZE;
                        end
                    end
                end
                PH_CH_SIZE, PH_TC_SIZE: begin
                    if (first && n > 4'd8) begin
                        err = ST_BAD_VINT;
                    end else if (first && n_ext > cbl_reg) begin
                        err = ST_OVERRUN;
                    end else begin
                        put_byte   = (ph == PH_CH_SIZE);
                        accum_next = take_acc;
                        fbl_next   = take_fbl;
                        vlen_next  = take_len;
                        cbl_next   = cbl_dec;
                        if (done) begin
                            if (size_bad) begin
                                err = ST_TOO_LONG;
                            end else if (size_val > cbl_dec) begin
                                err = ST_OVERRUN;
                            end else begin
                                child_next = size_val;
                                if (ph == PH_CH_SIZE) begin
                                    phase_next = (size_val != '0) ? PH_CH_DATA : PH_CH_ID;
                                end else begin
                                    accum_next = 64'd0;
                                    if (size_val == '0) begin
                                        put_tc     = 1'b1;
                                        phase_next = PH_TAIL;
                                    end else begin
                                        phase_next = PH_TC_DATA;
                                    end
                                end
                            end
                        end
                    end
                end
                PH_CH_DATA: begin
                    put_byte   = 1'b1;
                    cbl_next   = cbl_dec;
                    child_next = child_dec;
                    if (child_dec == '0) begin
                        phase_next = PH_CH_ID;
                    end
                end
                PH_TC_DATA: begin
                    cbl_next   = cbl_dec;
                    child_next = child_dec;
                    accum_next = {acc[55:0], s_tdata};
                    if (child_dec == '0) begin
                        put_tc     = 1'b1;
                        tc_val     = {acc[55:0], s_tdata};
                        phase_next = PH_TAIL;
                    end
                end
                PH_TAIL: begin
                    put_byte = 1'b1;
                    cbl_next = cbl_dec;
                end
                default: begin
                    err = ST_NOT_CLUSTER;
                end
            endcase

            // End of the cluster: closes normally only after the timecode.
            if (err == ST_OK && cbl_next == '0 &&
                (phase_next == PH_CH_ID || phase_next == PH_TAIL)) begin
                if (phase_next == PH_TAIL) begin
                    close      = 1'b1;
                    phase_next = PH_CL_ID;
                    fbl_next   = 4'd0;
                end else begin
                    err = ST_NO_TIMECODE;
                end
            end

            if (err != ST_OK) begin
                err_next   = 1'b1;
                phase_next = PH_CL_ID;
                fbl_next   = 4'd0;
            end
        end
    end

    // Command toward the emitter.
    always_comb begin
        push_cmd.is_tc  = put_tc && (err == ST_OK);
        push_cmd.data   = (err == ST_OK) ? s_tdata : 8'd0;
        push_cmd.valid  = (err == ST_OK);
        push_cmd.status = err;
        push_cmd.cend   = close || (err != ST_OK);
        push_cmd.tc     = tc_val;
        push = accept && !errl && (put_byte || put_tc || err != ST_OK);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_CL_ID;
            accum_reg <= 64'd0;
            fbl_reg   <= 4'd0;
            vlen_reg  <= 4'd0;
            cbl_reg   <= '0;
            child_reg <= '0;
            err_reg   <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            accum_reg <= accum_next;
            fbl_reg   <= fbl_next;
            vlen_reg  <= vlen_next;
            cbl_reg   <= cbl_next;
            child_reg <= child_next;
            err_reg   <= err_next;
        end
    end

endmodule

>>> rtl/ecrb_queue.sv
module ecrb_queue
    import ecrb_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    output logic q_valid,
    output cmd_t q_cmd,
    input  logic pop
);

    cmd_t                 mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_reg, wr_next;
    logic [Q_PTR_W-1:0]   rd_reg, rd_next;
    logic [Q_PTR_W:0]     cnt_reg, cnt_next;

    assign full    = (cnt_reg == (Q_PTR_W + 1)'(Q_DEPTH));
    assign q_valid = (cnt_reg != '0);
    assign q_cmd   = mem_reg[rd_reg];

    // Pointer and fill count update.
    always_comb begin
        wr_next  = push ? wr_reg + Q_PTR_W'(1) : wr_reg;
        rd_next  = pop ? rd_reg + Q_PTR_W'(1) : rd_reg;
        cnt_next = cnt_reg + (Q_PTR_W + 1)'(push) - (Q_PTR_W + 1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_reg] <= push_cmd;
        end
    end

endmodule

>>> rtl/ecrb_back.sv
module ecrb_back
    import ecrb_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_valid,
    input  cmd_t        q_cmd,
    output logic        pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,
    output logic [1:0]  m_tuser,
    output logic        m_tlast
);

    typedef enum logic [3:0] {
        BK_IDLE = 4'b0001,
        BK_CMP  = 4'b0010,
        BK_UPD  = 4'b0100,
        BK_EMIT = 4'b1000
    } bk_state_t;

    bk_state_t   st_reg, st_next;
    logic [63:0] shift_reg, shift_next;
    logic [63:0] last_reg, last_next;
    logic [63:0] tc_reg, tc_next;
    logic [63:0] sum_reg, sum_next;
    logic [63:0] diff_reg, diff_next;
    logic [63:0] emit_reg, emit_next;
    logic        cend_reg, cend_next;
    logic [3:0]  cnt_reg, cnt_next;

    logic        ov_reg, ov_next;
    logic [7:0]  ob_reg, ob_next;
    logic        obv_reg, obv_next;
    status_t     ost_reg, ost_next;
    logic        oce_reg, oce_next;
    logic        olast_reg, olast_next;

    logic        out_free;
    logic        bump;
    logic [63:0] new_last;

    assign out_free = !ov_reg || m_tready;
    assign bump     = (sum_reg <= last_reg);
    assign new_last = bump ? last_reg + 64'd1 : sum_reg;

    // Emitter sequencer and output register.
    always_comb begin
        st_next    = st_reg;
        shift_next = shift_reg;
        last_next  = last_reg;
        tc_next    = tc_reg;
        sum_next   = sum_reg;
        diff_next  = diff_reg;
        emit_next  = emit_reg;
        cend_next  = cend_reg;
        cnt_next   = cnt_reg;
        ov_next    = ov_reg && !m_tready;
        ob_next    = ob_reg;
        obv_next   = obv_reg;
        ost_next   = ost_reg;
        oce_next   = oce_reg;
        olast_next = olast_reg;
        pop        = 1'b0;
        unique case (st_reg)
            BK_IDLE: begin
                if (q_valid && q_cmd.is_tc) begin
                    pop       = 1'b1;
                    tc_next   = q_cmd.tc;
                    cend_next = q_cmd.cend;
                    st_next   = BK_CMP;
                end else if (q_valid && out_free) begin
                    pop        = 1'b1;
                    ov_next    = 1'b1;
                    ob_next    = q_cmd.data;
                    obv_next   = q_cmd.valid;
                    ost_next   = q_cmd.status;
                    oce_next   = q_cmd.cend;
                    olast_next = 1'b1;
                end
            end
            BK_CMP: begin
                sum_next  = shift_reg + tc_reg;
                diff_next = last_reg - tc_reg;
                st_next   = BK_UPD;
            end
            BK_UPD: begin
                // Keep timecodes strictly rising.
                if (bump) begin
                    shift_next = diff_reg + 64'd1;
                end
                last_next = new_last;
                emit_next = new_last;
                cnt_next  = 4'd0;
                st_next   = BK_EMIT;
            end
            BK_EMIT: begin
                if (out_free) begin
                    ov_next    = 1'b1;
                    obv_next   = 1'b1;
                    ost_next   = ST_OK;
                    olast_next = (cnt_reg == 4'd8);
                    oce_next   = cend_reg && (cnt_reg == 4'd8);
                    if (cnt_reg == 4'd0) begin
                        ob_next = TC_SIZE_CODE;
                    end else begin
                        ob_next   = emit_reg[63:56];
                        emit_next = {emit_reg[55:0], 8'd0};
                    end
                    cnt_next = cnt_reg + 4'd1;
                    if (cnt_reg == 4'd8) begin
                        st_next = BK_IDLE;
                    end
                end
            end
            default: begin
                st_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg    <= BK_IDLE;
            shift_reg <= 64'd0;
            last_reg  <= 64'd0;
            ov_reg    <= 1'b0;
            cnt_reg   <= 4'd0;
        end else begin
            st_reg    <= st_next;
            shift_reg <= shift_next;
            last_reg  <= last_next;
            ov_reg    <= ov_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        tc_reg    <= tc_next;
        sum_reg   <= sum_next;
        diff_reg  <= diff_next;
        emit_reg  <= emit_next;
        cend_reg  <= cend_next;
        ob_reg    <= ob_next;
        obv_reg   <= obv_next;
        ost_reg   <= ost_next;
        oce_reg   <= oce_next;
        olast_reg <= olast_next;
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = {5'd0, ost_reg, ob_reg};
    assign m_tuser  = {oce_reg, obv_reg};
    assign m_tlast  = olast_reg;

endmodule

>>> rtl/ebml_cluster_timecode_rebase_unit.sv
// A passed-through byte or an error result passes the queue and then the output register.
// A Timecode child passes the queue, compare and update states before its nine results.
// Throughput: one byte per cycle while the queue has room; a Timecode child holds the
// emitter (take, compare, update, nine beats); the four-entry queue keeps the parser going.
// Reset (aresetn, synchronous, active low) clears the shift, the last timecode and the parser.
module ebml_cluster_timecode_rebase_unit
    import ecrb_pkg::*;
#(
    parameter int unsigned LENGTH_BITS = 24
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tuser,   // [0] cluster_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] out_byte, [10:8] status, [15:11] zero
    output logic [1:0]  m_tuser,   // [0] byte_valid, [1] cluster_end
    output logic        m_tlast    // last_of_run
);

    logic push;
    cmd_t push_cmd;
    logic q_full;
    logic q_valid;
    cmd_t q_cmd;
    logic pop;

    ecrb_front #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .q_full  (q_full),
        .push    (push),
        .push_cmd(push_cmd)
    );

    ecrb_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .push_cmd(push_cmd),
        .full    (q_full),
        .q_valid (q_valid),
        .q_cmd   (q_cmd),
        .pop     (pop)
    );

    ecrb_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_cmd   (q_cmd),
        .pop     (pop),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

endmodule

>>> bench/ebml_cluster_timecode_rebase_checker.sv
`timescale 1ns / 100ps

// Watches both channels of the timecode rebase unit, predicts the result beats
// of every accepted request and compares them with what the unit delivers.
module ebml_cluster_timecode_rebase_checker
    import ecrb_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    input  logic [1:0]  m_tuser,
    input  logic        m_tlast,
    output int          fail_count,
    output int          beats_owed
);

    localparam logic [63:0] SIZE_LIMIT = (64'd1 << 24) - 64'd1;

    typedef struct {
        logic [7:0] data;
        logic       byte_ok;
        status_t    status;
        logic       cend;
        logic       run_last;
    } out_beat_t;

    // Parser and rebase state of the predictor.
    logic [63:0] shift_amt;
    logic [63:0] prev_tc;
    phase_t      phase;
    logic [63:0] acc;
    int unsigned acc_left;
    logic [31:0] elem_id;
    logic [63:0] cluster_left;
    logic [63:0] child_left;
    logic        tc_seen;
    logic        err_hold;

    out_beat_t   step_beats[$];
    out_beat_t   expected_beats[$];

    assign beats_owed = expected_beats.size();

    // Number of bytes in a vint, taken from its first byte; nine for zero.
    function automatic int unsigned vint_bytes(logic [7:0] b);
        for (int i = 0; i < 8; i++) begin
            if (b[7-i]) return i + 1;
        end
        return 9;
    endfunction

    function automatic status_t vint_gather(logic [7:0] b, int unsigned max_len);
        int unsigned n;
        if (acc_left == 0) begin
            n = vint_bytes(b);
            if (n > max_len) return ST_BAD_VINT;
            acc = {56'd0, b};
            acc_left = n - 1;
        end else begin
            acc = {acc[55:0], b};
            acc_left--;
        end
        return ST_OK;
    endfunction

    // Removes the length marker from a complete size vint.
    function automatic status_t size_value(logic [63:0] raw, output logic [63:0] v);
        logic [63:0] top;
        top = '0;
        for (int i = 63; i >= 0; i--) begin
            if (raw[i]) begin
                top[i] = 1'b1;
                break;
            end
        end
        v = raw ^ top;
        if ((raw & (raw + 64'd1)) == 64'd0) return ST_TOO_LONG;
        return (v > SIZE_LIMIT) ? ST_TOO_LONG : ST_OK;
    endfunction

    // Checks applied to the first byte of a vint inside the cluster body.
    function automatic status_t body_vint_status(logic [7:0] b, int unsigned max_len);
        int unsigned n;
        if (acc_left != 0) return ST_OK;
        n = vint_bytes(b);
        if (n > max_len) return ST_BAD_VINT;
        if (64'(n) > cluster_left) return ST_OVERRUN;
        return ST_OK;
    endfunction

    function automatic void add_beat(logic [7:0] d);
        step_beats.insert(step_beats.size(), '{d, 1'b1, ST_OK, 1'b0, 1'b0});
    endfunction

    // Rebases the gathered timecode and queues the rewritten element body.
    function automatic void rebase_timecode();
        logic [63:0] tc;
        tc = acc;
        if (shift_amt + tc <= prev_tc) shift_amt = prev_tc + 64'd1 - tc;
        prev_tc = tc + shift_amt;
        add_beat(TC_SIZE_CODE);
        for (int i = 0; i < 8; i++) add_beat(prev_tc[63-8*i -: 8]);
        tc_seen = 1'b1;
        phase = PH_TAIL;
    endfunction

    // Advances the parser by one request byte and queues its result beats.
    function automatic void predict_byte(logic [7:0] b, logic start);
        status_t     err;
        logic [63:0] v;
        logic        close;
        logic        is_child;
        err = ST_OK;
        close = 1'b0;
        v = '0;
        step_beats.delete();
        if (start) begin
            err_hold = 1'b0;
            phase = PH_CL_ID;
            acc_left = 0;
            acc = '0;
        end
        if (err_hold) return;

        case (phase)
            PH_CL_ID: begin
                if (acc_left == 0) tc_seen = 1'b0;
                err = vint_gather(b, 4);
                if (err == ST_OK) begin
                    add_beat(b);
                    if (acc_left == 0) begin
                        elem_id = acc[31:0];
                        if (elem_id != CLUSTER_ID) err = ST_NOT_CLUSTER;
                        else phase = PH_CL_SIZE;
                    end
                end
            end
            PH_CL_SIZE: begin
                err = vint_gather(b, 8);
                if (err == ST_OK) begin
                    add_beat(b);
                    if (acc_left == 0) begin
                        err = size_value(acc, v);
                        if (err == ST_OK) begin
                            cluster_left = v;
                            if (v == 0) err = ST_NO_TIMECODE;
                            else phase = PH_CH_ID;
                        end
                    end
                end
            end
            PH_CH_ID: begin
                err = body_vint_status(b, 4);
                if (err == ST_OK) begin
                    void'(vint_gather(b, 4));
                    cluster_left--;
                    add_beat(b);
                    if (acc_left == 0) begin
                        elem_id = acc[31:0];
                        phase = (elem_id == TIMECODE_ID) ? PH_TC_SIZE : PH_CH_SIZE;
                    end
                end
            end
            PH_CH_SIZE, PH_TC_SIZE: begin
                is_child = (phase == PH_CH_SIZE);
                err = body_vint_status(b, 8);
                if (err == ST_OK) begin
                    void'(vint_gather(b, 8));
                    cluster_left--;
                    if (is_child) add_beat(b);
                    if (acc_left == 0) begin
                        err = size_value(acc, v);
                        if (err == ST_OK) begin
                            if (v > cluster_left) begin
                                err = ST_OVERRUN;
                            end else begin
                                child_left = v;
                                if (is_child) begin
                                    phase = (v != 0) ? PH_CH_DATA : PH_CH_ID;
                                end else begin
                                    acc = '0;
                                    if (v == 0) rebase_timecode();
                                    else phase = PH_TC_DATA;
                                end
                            end
                        end
                    end
                end
            end
            PH_CH_DATA: begin
                add_beat(b);
                cluster_left--;
                child_left--;
                if (child_left == 0) phase = PH_CH_ID;
            end
            PH_TC_DATA: begin
                cluster_left--;
                child_left--;
                acc = {acc[55:0], b};
                if (child_left == 0) rebase_timecode();
            end
            default: begin
                add_beat(b);
                cluster_left--;
            end
        endcase

        // A cluster closes when its body is used up between children.
        if (err == ST_OK && (phase == PH_CH_ID || phase == PH_TAIL) && cluster_left == 0) begin
            if (tc_seen) begin
                close = 1'b1;
                phase = PH_CL_ID;
                acc_left = 0;
            end else begin
                err = ST_NO_TIMECODE;
            end
        end

        if (err != ST_OK) begin
            err_hold = 1'b1;
            phase = PH_CL_ID;
            acc_left = 0;
            expected_beats.insert(expected_beats.size(), '{8'h00, 1'b0, err, 1'b1, 1'b1});
            return;
        end
        if (step_beats.size() > 0) begin
            step_beats[step_beats.size()-1].run_last = 1'b1;
            step_beats[step_beats.size()-1].cend = close;
        end
        foreach (step_beats[i]) expected_beats.insert(expected_beats.size(), step_beats[i]);
    endfunction

    // Prediction on each accepted request, comparison on each accepted result.
    always @(posedge aclk) begin
        out_beat_t e;
        if (!aresetn) begin
            shift_amt = '0;
            prev_tc = '0;
            phase = PH_CL_ID;
            acc = '0;
            acc_left = 0;
            elem_id = '0;
            cluster_left = '0;
            child_left = '0;
            tc_seen = 1'b0;
            err_hold = 1'b0;
            fail_count = 0;
            expected_beats.delete();
        end else begin
            if (s_tvalid && s_tready) predict_byte(s_tdata, s_tuser);
            if (m_tvalid && m_tready) begin
                if (expected_beats.size() == 0) begin
                    $error("result beat with nothing expected: tdata %0h tuser %0h",
                           m_tdata, m_tuser);
                    fail_count++;
                end else begin
                    e = expected_beats.pop_front();
                    if (m_tdata[7:0] !== e.data) begin
                        $error("out_byte: expected %0h, actual %0h", e.data, m_tdata[7:0]);
                        fail_count++;
                    end
                    if (m_tuser[0] !== e.byte_ok) begin
                        $error("byte_valid: expected %0b, actual %0b", e.byte_ok, m_tuser[0]);
                        fail_count++;
                    end
                    if (m_tdata[10:8] !== e.status) begin
                        $error("status: expected %0d, actual %0d", e.status, m_tdata[10:8]);
                        fail_count++;
                    end
                    if (m_tuser[1] !== e.cend) begin
                        $error("cluster_end: expected %0b, actual %0b", e.cend, m_tuser[1]);
                        fail_count++;
                    end
                    if (m_tlast !== e.run_last) begin
                        $error("last_of_run: expected %0b, actual %0b", e.run_last, m_tlast);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

>>> bench/ebml_cluster_timecode_rebase_unit_tb.sv
`timescale 1ns / 100ps

// Drives cluster byte streams into the timecode rebase unit under varying
// backpressure and gives the verdict from the checker's failure count and owed beats.
module ebml_cluster_timecode_rebase_unit_tb;
    import ecrb_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    int          fail_count;
    int          beats_owed;

    int          send_idle_pct;
    int          recv_stall_pct;
    logic        long_hold_req;
    logic        prev_clean;
    logic [7:0]  frame[$];
    logic [7:0]  body[$];

    ebml_cluster_timecode_rebase_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    ebml_cluster_timecode_rebase_checker i_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .beats_owed (beats_owed)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Overall time limit.
    initial begin
        #4ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Receiver: random stalls, plus one long hold-off when requested.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (long_hold_req) begin
                m_tready <= 1'b0;
                repeat (300) @(negedge aclk);
                m_tready <= 1'b1;
                long_hold_req = 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // Offers one request byte and waits until it is taken.
    task automatic send_byte(logic [7:0] b, logic start);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat ($urandom_range(0, 3)) @(negedge aclk);
        end else begin
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tuser <= start;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Sends the byte list in frame; the first byte carries the given start flag.
    task automatic send_frame(logic start);
        foreach (frame[i]) send_byte(frame[i], (i == 0) ? start : 1'b0);
    endtask

    task automatic add_size(int unsigned n);
        if (n < 127 && $urandom_range(0, 1)) begin
            body.insert(body.size(), 8'h80 | n[7:0]);
        end else if ($urandom_range(0, 1)) begin
            body.insert(body.size(), 8'h40 | n[13:8]);
            body.insert(body.size(), n[7:0]);
        end else begin
            body.insert(body.size(), 8'h01);
            repeat (5) body.insert(body.size(), 8'h00);
            body.insert(body.size(), n[15:8]);
            body.insert(body.size(), n[7:0]);
        end
    endtask

    // Builds a well-formed cluster in frame with random children and timecode.
    task automatic build_cluster(logic [63:0] tc);
        logic [7:0]  id;
        int unsigned len;
        int unsigned n;
        logic [7:0]  hdr[$];
        body.delete();
        repeat ($urandom_range(0, 2)) begin
            if ($urandom_range(0, 1)) begin
                do id = 8'h80 | 8'($urandom_range(0, 127)); while (id == 8'hE7);
                body.insert(body.size(), id);
            end else begin
                body.insert(body.size(), 8'h40 | 8'($urandom_range(0, 63)));
                body.insert(body.size(), 8'($urandom));
            end
            len = $urandom_range(0, 4);
            add_size(len);
            repeat (len) body.insert(body.size(), 8'($urandom));
        end
        len = $urandom_range(0, 8);
        body.insert(body.size(), 8'hE7);
        add_size(len);
        for (int i = 0; i < len; i++) body.insert(body.size(), tc[8*(len-1-i) +: 8]);
        repeat ($urandom_range(0, 4)) body.insert(body.size(), 8'($urandom));
        n = body.size();
        // Cluster header goes in front of the body.
        frame = '{8'h1F, 8'h43, 8'hB6, 8'h75};
        hdr = body;
        body.delete();
        add_size(n);
        frame = {frame, body, hdr};
    endtask

    function automatic logic [63:0] pick_timecode();
        case ($urandom_range(0, 3))
            0: return 64'($urandom_range(0, 1000));
            1: return 64'd0;
            2: return {$urandom, $urandom};
            default: return '1;
        endcase
    endfunction

    // One random cluster: mostly well-formed, some corrupted, some noise.
    task automatic random_cluster();
        int unsigned pick;
        int unsigned pos;
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            frame.delete();
            repeat ($urandom_range(1, 6)) frame.insert(frame.size(), 8'($urandom));
            send_frame(1'($urandom_range(0, 1)));
            prev_clean = 1'b0;
        end else begin
            build_cluster(pick_timecode());
            if (pick == 1) begin
                pos = $urandom_range(0, frame.size() - 1);
                frame[pos] = 8'($urandom);
            end
            send_frame(prev_clean ? 1'($urandom_range(0, 1)) : 1'b1);
            prev_clean = (pick != 1);
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        long_hold_req = 1'b0;
        prev_clean = 1'b0;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: rebase cases, timecode extremes and every error status.
        frame = '{8'h1F, 8'h43, 8'hB6, 8'h75, 8'h84, 8'hE7, 8'h81, 8'h05, 8'hAA};
        send_frame(1'b1);
        frame = '{8'h1F, 8'h43, 8'hB6, 8'h75, 8'h83, 8'hE7, 8'h81, 8'h03};
        send_frame(1'b0);
        frame = '{8'h1F, 8'h43, 8'hB6, 8'h75, 8'h85, 8'hA3, 8'h80, 8'hE7, 8'h80, 8'h11};
        send_frame(1'b0);
        frame = '{8'h1F, 8'h43, 8'hB6, 8'h75, 8'h8A, 8'hE7, 8'h88,
                  8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        send_frame(1'b1);
        frame = '{8'h1F, 8'h43, 8'hB6, 8'h75, 8'h8A, 8'hE7, 8'h88,
                  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
        send_frame(1'b0);
        frame = '{8'h1A, 8'h45, 8'hDF, 8'hA3, 8'h81, 8'h00};
        send_frame(1'b1);
        frame = '{8'h00};
        send_frame(1'b1);
        frame = '{8'h08};
        send_frame(1'b1);
        frame = '{8'h1F, 8'h43, 8'hB6, 8'h75, 8'hFF};
        send_frame(1'b1);
        frame = '{8'h1F, 8'h43, 8'hB6, 8'h75, 8'h80};
        send_frame(1'b1);
        frame = '{8'h1F, 8'h43, 8'hB6, 8'h75, 8'h11, 8'h00, 8'h00, 8'h00};
        send_frame(1'b1);
        frame = '{8'h1F, 8'h43, 8'hB6, 8'h75, 8'h83, 8'hA3, 8'h81, 8'h55};
        send_frame(1'b1);
        frame = '{8'h1F, 8'h43, 8'hB6, 8'h75, 8'h83, 8'hA3, 8'h85};
        send_frame(1'b1);
        frame = '{8'h1F, 8'h43, 8'hB6, 8'h75, 8'h81, 8'h40};
        send_frame(1'b1);
        frame = '{8'h1F, 8'h43, 8'hB6, 8'h75, 8'h81, 8'h00};
        send_frame(1'b1);
        frame = '{8'h1F, 8'h43, 8'hB6, 8'h75, 8'h83, 8'hE7, 8'hFF};
        send_frame(1'b1);

        // Random clusters across the idling phases; a long hold-off in the third.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
                default: begin send_idle_pct = 33; recv_stall_pct = 33; end
            endcase
            if (ph == 2) long_hold_req = 1'b1;
            repeat ((ph == 2) ? 2 : 1) random_cluster();
            long_hold_req = 1'b0;
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;
        repeat (2) @(posedge aclk);
        while (beats_owed != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (fail_count == 0 && beats_owed == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/ecrb_pkg.sv
rtl/ecrb_front.sv
rtl/ecrb_queue.sv
rtl/ecrb_back.sv
rtl/ebml_cluster_timecode_rebase_unit.sv
bench/ebml_cluster_timecode_rebase_checker.sv
bench/ebml_cluster_timecode_rebase_unit_tb.sv
